// File: hw/rtl/gbi_pkg.sv
// Shared types and constants of the grid bilinear interpolator.
// Holds the request and result structs, mode and register codes, and FSM state types.
// No dependencies.
`default_nettype none

package gbi_pkg;

    localparam logic [1:0] MODE_LOAD_X    = 2'd0;
    localparam logic [1:0] MODE_LOAD_Y    = 2'd1;
    localparam logic [1:0] MODE_LOAD_SURF = 2'd2;
    localparam logic [1:0] MODE_QUERY     = 2'd3;

    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

    // Numerator magnitude, divisor, kept quotient bits, divider counter, accumulator width.
    localparam int NUM_W     = 98;
    localparam int DEN_W     = 64;
    localparam int QUOT_W    = 34;
    localparam int DIV_CNT_W = 7;
    localparam int ACC_W     = NUM_W + 1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [6:0]         row_index;
        logic [6:0]         col_index;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [6:0]         x_lower_node;
        logic [6:0]         y_lower_node;
        logic               on_node;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_DONE
    } search_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SEARCH,
        T_FETCH,
        T_MUL,
        T_AREA,
        T_AREA_WAIT,
        T_DIV,
        T_FINISH
    } top_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/gbi_axis_search.sv
// Axis node memory with a node-by-node bracket search.
// Depends on gbi_pkg (search_state_t).
`default_nettype none

module gbi_axis_search #(
    parameter int DEPTH = 128
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [31:0]                wr_data,
    input  logic [7:0]                 count,
    input  logic                       start,
    input  logic signed [31:0]         point,
    output logic                       done,
    output logic [$clog2(DEPTH)-1:0]   lo_idx,
    output logic [$clog2(DEPTH)-1:0]   hi_idx,
    output logic signed [31:0]         lo_val,
    output logic signed [31:0]         hi_val
);
    import gbi_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [31:0]        mem [DEPTH];
    logic [IW-1:0]      raddr;
    logic signed [31:0] rdata_reg;

    search_state_t      state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      last_idx;
    logic signed [31:0] prev_reg, prev_next;
    logic [IW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic signed [31:0] lov_reg, lov_next, hiv_reg, hiv_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[raddr];
    end

    // A count of zero acts as one, a count past the depth as the depth.
    always_comb begin
        if (count == 8'd0) begin
            last_idx = '0;
        end else if (32'(count) > DEPTH) begin
            last_idx = IW'(DEPTH - 1);
        end else begin
            last_idx = IW'(32'(count) - 32'd1);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_DONE: begin
                if (start) state_next = S_FIRST;
            end
            S_FIRST: begin
                state_next = (point <= rdata_reg) ? S_DONE : S_LAST;
            end
            S_LAST: begin
                state_next = (point >= rdata_reg) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (point <= rdata_reg) state_next = S_DONE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        idx_next  = idx_reg;
        prev_next = prev_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        lov_next  = lov_reg;
        hiv_next  = hiv_reg;
        raddr     = '0;
        case (state_reg)
            S_FIRST: begin
                raddr = last_idx;
                if (point <= rdata_reg) begin
                    lo_next  = '0;
                    hi_next  = '0;
                    lov_next = rdata_reg;
                    hiv_next = rdata_reg;
                end else begin
                    prev_next = rdata_reg;
                end
            end
            S_LAST: begin
                raddr = IW'(1);
                if (point >= rdata_reg) begin
                    lo_next  = last_idx;
                    hi_next  = last_idx;
                    lov_next = rdata_reg;
                    hiv_next = rdata_reg;
                end else begin
                    idx_next = IW'(1);
                end
            end
            S_SCAN: begin
                raddr = idx_reg + IW'(1);
                if (point < rdata_reg) begin
                    lo_next  = idx_reg - IW'(1);
                    hi_next  = idx_reg;
                    lov_next = prev_reg;
                    hiv_next = rdata_reg;
                end else if (point == rdata_reg) begin
                    lo_next  = idx_reg;
                    hi_next  = idx_reg;
                    lov_next = rdata_reg;
                    hiv_next = rdata_reg;
                end else begin
                    // advance past this node
                    prev_next = rdata_reg;
                    idx_next  = idx_reg + IW'(1);
                end
            end
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        lov_reg  <= lov_next;
        hiv_reg  <= hiv_next;
    end

    assign done   = (state_reg == S_DONE);
    assign lo_idx = lo_reg;
    assign hi_idx = hi_reg;
    assign lo_val = lov_reg;
    assign hi_val = hiv_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gbi_divider.sv
// Restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on gbi_pkg (NUM_W, DEN_W, QUOT_W, DIV_CNT_W).
`default_nettype none

module gbi_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gbi_pkg::NUM_W-1:0]   num,
    input  logic [gbi_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [gbi_pkg::QUOT_W-1:0]  quot,
    output logic                        ovf
);
    import gbi_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic                 ovf_reg, ovf_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;
    logic                 fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = DIV_CNT_W'(NUM_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            ovf_next  = ovf_reg | quot_reg[QUOT_W-1];
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// File: hw/rtl/grid_bilinear_interpolator.sv
// Top level of the grid bilinear interpolator: sequencer, surface memory, multiplier.
// Depends on gbi_pkg, gbi_axis_search and gbi_divider.
`default_nettype none

//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------
//  s_        | in        | s_valid / s_ready  | in_item_t  (load or query)
//  m_        | out       | m_valid / m_ready  | out_item_t (one per query)
//  APB       | in        | psel/penable/pready| x_count at 0x0, y_count at 0x4
//
//  A load request is written straight into its memory.
//  A query runs the two axis searches side by side, one node per cycle on each axis
//  memory port, then fetches the corners and accumulates its terms (4 for a bilinear
//  cell, 1 on an axis node and 0 on a grid node, where the divider is skipped). It
//  then divides the sum by the cell area, or by the axis span on an axis node, using the
//  one-bit-per-cycle divider over the exact 98-bit numerator.
//  Reset clears control state and sets both counts to 128; memories are not cleared.
//  A finished result waits in the output register; loads keep flowing meanwhile.

module grid_bilinear_interpolator #(
    parameter int X_POINTS = 128,
    parameter int Y_POINTS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gbi_pkg::in_item_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output gbi_pkg::out_item_t  m_payload,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gbi_pkg::*;

    localparam int XW  = $clog2(X_POINTS);
    localparam int YW  = $clog2(Y_POINTS);
    localparam int SD  = X_POINTS * Y_POINTS;
    localparam int SAW = $clog2(SD);

    // ---------------- configuration registers ----------------
    logic [7:0] x_count_reg, y_count_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_count_reg <= 8'd128;
            y_count_reg <= 8'd128;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_X_COUNT: x_count_reg <= pwdata[7:0];
                REG_Y_COUNT: y_count_reg <= pwdata[7:0];
                default:     x_count_reg <= x_count_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_X_COUNT: prdata = {24'b0, x_count_reg};
            REG_Y_COUNT: prdata = {24'b0, y_count_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- request decode ----------------
    top_state_t state_reg, state_next;
    logic       s_accept;
    logic       is_query;
    logic       x_we, y_we, surf_we;

    assign s_ready  = (state_reg == T_IDLE);
    assign s_accept = s_valid & s_ready;
    assign is_query = (s_payload.mode == MODE_QUERY);
    // Drop loads whose index lies past the store.
    assign x_we = s_accept && (s_payload.mode == MODE_LOAD_X)
                  && (32'(s_payload.row_index) < X_POINTS);
    assign y_we = s_accept && (s_payload.mode == MODE_LOAD_Y)
                  && (32'(s_payload.col_index) < Y_POINTS);
    assign surf_we = s_accept && (s_payload.mode == MODE_LOAD_SURF)
                     && (32'(s_payload.row_index) < X_POINTS)
                     && (32'(s_payload.col_index) < Y_POINTS);

    // ---------------- axis searches ----------------
    logic signed [31:0] qx_reg, qx_next, qy_reg, qy_next;
    logic               x_done, y_done;
    logic [XW-1:0]      x_lo, x_hi;
    logic [YW-1:0]      y_lo, y_hi;
    logic signed [31:0] x1, x2, y1, y2;
    logic               search_start;

    assign search_start = s_accept & is_query;

    gbi_axis_search #(.DEPTH(X_POINTS)) u_x_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (x_we),
        .wr_addr (XW'(32'(s_payload.row_index))),
        .wr_data (s_payload.load_value),
        .count   (x_count_reg),
        .start   (search_start),
        .point   (qx_reg),
        .done    (x_done),
        .lo_idx  (x_lo),
        .hi_idx  (x_hi),
        .lo_val  (x1),
        .hi_val  (x2)
    );

    gbi_axis_search #(.DEPTH(Y_POINTS)) u_y_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (y_we),
        .wr_addr (YW'(32'(s_payload.col_index))),
        .wr_data (s_payload.load_value),
        .count   (y_count_reg),
        .start   (search_start),
        .point   (qy_reg),
        .done    (y_done),
        .lo_idx  (y_lo),
        .hi_idx  (y_hi),
        .lo_val  (y1),
        .hi_val  (y2)
    );

    // ---------------- surface memory ----------------
    logic [31:0]        surf_mem [SD];
    logic [SAW-1:0]     surf_waddr, surf_raddr;
    logic signed [31:0] surf_rdata_reg;
    logic [2:0]         fetch_cnt_reg, fetch_cnt_next;

    assign surf_waddr = SAW'(32'(s_payload.row_index) * Y_POINTS
                             + 32'(s_payload.col_index));

    always_ff @(posedge aclk) begin
        if (surf_we) begin
            surf_mem[surf_waddr] <= s_payload.load_value;
        end
        surf_rdata_reg <= surf_mem[surf_raddr];
    end

    // Corner order: (lo,lo), (hi,lo), (lo,hi), (hi,hi) in (x,y).
    always_comb begin
        case (fetch_cnt_reg[1:0])
            2'd0:    surf_raddr = SAW'(32'(x_lo) * Y_POINTS + 32'(y_lo));
            2'd1:    surf_raddr = SAW'(32'(x_hi) * Y_POINTS + 32'(y_lo));
            2'd2:    surf_raddr = SAW'(32'(x_lo) * Y_POINTS + 32'(y_hi));
            default: surf_raddr = SAW'(32'(x_hi) * Y_POINTS + 32'(y_hi));
        endcase
    end

    // ---------------- term selection ----------------
    logic signed [31:0] f11_reg, f11_next, f21_reg, f21_next;
    logic signed [31:0] f12_reg, f12_next, f22_reg, f22_next;
    logic               xe, ye, bilin;
    logic signed [32:0] dx_hi, dx_lo, dy_hi, dy_lo, dxa, dya, fd_x, fd_y;
    logic [1:0]         term_reg, term_next, phase_reg, phase_next;
    logic [1:0]         last_term;
    logic signed [32:0] tf;
    logic [31:0]        tp, tq, den_a, den_b;
    logic               f_neg;
    logic [31:0]        f_mag;

    assign xe    = (x_lo == x_hi);
    assign ye    = (y_lo == y_hi);
    assign bilin = !xe && !ye;

    assign dx_hi = 33'(x2) - 33'(qx_reg);
    assign dx_lo = 33'(qx_reg) - 33'(x1);
    assign dy_hi = 33'(y2) - 33'(qy_reg);
    assign dy_lo = 33'(qy_reg) - 33'(y1);
    assign dxa   = 33'(x2) - 33'(x1);
    assign dya   = 33'(y2) - 33'(y1);
    assign fd_x  = 33'(f21_reg) - 33'(f11_reg);
    assign fd_y  = 33'(f12_reg) - 33'(f11_reg);

    assign last_term = bilin ? 2'd3 : 2'd0;

    // Bracketing is strict off a node, so every distance is positive and fits 32 bits.
    always_comb begin
        if (bilin) begin
            den_a = dxa[31:0];
            den_b = dya[31:0];
            case (term_reg)
                2'd0: begin tf = 33'(f11_reg); tp = dx_hi[31:0]; tq = dy_hi[31:0]; end
                2'd1: begin tf = 33'(f21_reg); tp = dx_lo[31:0]; tq = dy_hi[31:0]; end
                2'd2: begin tf = 33'(f12_reg); tp = dx_hi[31:0]; tq = dy_lo[31:0]; end
                default: begin
                    tf = 33'(f22_reg); tp = dx_lo[31:0]; tq = dy_lo[31:0];
                end
            endcase
        end else if (xe) begin
            tf    = fd_y;
            tp    = dy_lo[31:0];
            tq    = 32'd1;
            den_a = dya[31:0];
            den_b = 32'd1;
        end else begin
            tf    = fd_x;
            tp    = dx_lo[31:0];
            tq    = 32'd1;
            den_a = dxa[31:0];
            den_b = 32'd1;
        end
    end

    assign f_neg = tf[32];
    assign f_mag = f_neg ? 32'(-tf) : tf[31:0];

    // ---------------- multiplier and accumulator ----------------
    logic [31:0]              mul_a, mul_b;
    logic [63:0]              prod_reg;
    logic [31:0]              hi_reg, hi_next;
    logic [63:0]              lo_reg, lo_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [95:0]              term_val;
    logic [ACC_W-1:0]         term_ext;
    logic [ACC_W-1:0]         acc_abs;
    logic                     acc_neg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign term_val = {prod_reg, 32'b0} + {32'b0, lo_reg};
    assign term_ext = ACC_W'(term_val);
    assign acc_neg  = acc_reg[ACC_W-1];
    assign acc_abs  = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // ---------------- divider ----------------
    logic                div_start, div_done, div_ovf;
    logic [DEN_W-1:0]    div_den;
    logic [QUOT_W-1:0]   div_quot;

    // An area at or above 2^63 is divided with its low bit cleared.
    assign div_den = prod_reg[63] ? {prod_reg[63:1], 1'b0} : prod_reg;

    gbi_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_abs[NUM_W-1:0]),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    logic signed [35:0] q_s, base_s, sum_s;
    logic signed [31:0] res_final;

    assign q_s    = acc_neg ? -$signed(36'(div_quot)) : $signed(36'(div_quot));
    assign base_s = bilin ? 36'sd0 : 36'(f11_reg);
    assign sum_s  = q_s + base_s;

    always_comb begin
        if (div_ovf) begin
            res_final = acc_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (sum_s > 36'sd2147483647) begin
            res_final = 32'sh7FFF_FFFF;
        end else if (sum_s < -36'sd2147483648) begin
            res_final = 32'sh8000_0000;
        end else begin
            res_final = sum_s[31:0];
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] res_reg, res_next;
    out_item_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (search_start) state_next = T_SEARCH;
            end
            T_SEARCH: begin
                if (x_done && y_done) state_next = T_FETCH;
            end
            T_FETCH: begin
                if (fetch_cnt_reg == 3'd4) state_next = (xe && ye) ? T_FINISH : T_MUL;
            end
            T_MUL: begin
                if (phase_reg == 2'd3 && term_reg == last_term) state_next = T_AREA;
            end
            T_AREA:      state_next = T_AREA_WAIT;
            T_AREA_WAIT: state_next = T_DIV;
            T_DIV: begin
                if (div_done) state_next = T_FINISH;
            end
            T_FINISH: begin
                if (out_free) state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    // ---------------- sequencer: datapath ----------------
    always_comb begin
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        fetch_cnt_next = fetch_cnt_reg;
        f11_next       = f11_reg;
        f21_next       = f21_reg;
        f12_next       = f12_reg;
        f22_next       = f22_reg;
        term_next      = term_reg;
        phase_next     = phase_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            T_IDLE: begin
                if (s_accept) begin
                    qx_next = s_payload.query_x;
                    qy_next = s_payload.query_y;
                end
                fetch_cnt_next = '0;
            end
            T_SEARCH: begin
                fetch_cnt_next = '0;
            end
            T_FETCH: begin
                // Read data is registered, so it arrives in the cycle after its address.
                fetch_cnt_next = fetch_cnt_reg + 3'd1;
                case (fetch_cnt_reg)
                    3'd1:    f11_next = surf_rdata_reg;
                    3'd2:    f21_next = surf_rdata_reg;
                    3'd3:    f12_next = surf_rdata_reg;
                    3'd4:    f22_next = surf_rdata_reg;
                    default: f11_next = f11_reg;
                endcase
                if (fetch_cnt_reg == 3'd4) begin
                    term_next  = '0;
                    phase_next = '0;
                    acc_next   = '0;
                    res_next   = f11_reg;
                end
            end
            T_MUL: begin
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0: begin
                        mul_a = tp;
                        mul_b = tq;
                    end
                    2'd1: begin
                        mul_a   = f_mag;
                        mul_b   = prod_reg[31:0];
                        hi_next = prod_reg[63:32];
                    end
                    2'd2: begin
                        mul_a   = f_mag;
                        mul_b   = hi_reg;
                        lo_next = prod_reg;
                    end
                    default: begin
                        acc_next  = f_neg ? acc_reg - $signed(term_ext)
                                          : acc_reg + $signed(term_ext);
                        term_next = term_reg + 2'd1;
                    end
                endcase
            end
            T_AREA: begin
                mul_a = den_a;
                mul_b = den_b;
            end
            T_AREA_WAIT: begin
                div_start = 1'b1;
            end
            T_DIV: begin
                if (div_done) res_next = res_final;
            end
            T_FINISH: begin
                if (out_free) begin
                    out_next.interp_value = res_reg;
                    out_next.x_lower_node = 7'(32'(x_lo));
                    out_next.y_lower_node = 7'(32'(y_lo));
                    out_next.on_node      = xe && ye;
                    m_valid_next          = 1'b1;
                end
            end
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        fetch_cnt_reg <= fetch_cnt_next;
        f11_reg       <= f11_next;
        f21_reg       <= f21_next;
        f12_reg       <= f12_next;
        f22_reg       <= f22_next;
        term_reg      <= term_next;
        phase_reg     <= phase_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        acc_reg       <= acc_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

// File: tb/gbi_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the grid bilinear interpolator: mirrors the axis and surface stores,
// predicts each query result and compares it with the block's output. Depends on gbi_pkg.
module gbi_checker
    import gbi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_results
);

    logic signed [31:0] x_nodes [128];
    logic signed [31:0] y_nodes [128];
    logic signed [31:0] surface [128][128];
    logic [7:0]         x_count_reg;
    logic [7:0]         y_count_reg;
    out_item_t          expected_q [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        x_count_reg     = 8'd128;
        y_count_reg     = 8'd128;
    end

    function automatic int nodes_in_use(logic [7:0] r);
        int n;
        n = r;
        if (n < 1) n = 1;
        if (n > 128) n = 128;
        return n;
    endfunction

    function automatic logic signed [131:0] wide(longint v);
        return v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Truncated quotient of an exact sum by a positive divisor, clamped to +-2^40.
    function automatic longint quotient_trunc(logic signed [131:0] num, logic [63:0] den);
        logic [131:0] mag;
        logic [131:0] q;
        logic         neg;
        neg = num[131];
        mag = neg ? -num : num;
        if (den == 0) return 0;
        q = mag / {68'd0, den};
        if (q > (132'd1 << 40)) q = 132'd1 << 40;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic void find_bracket(bit on_y, int n, longint v,
                                         output int lo, output int hi);
        longint a;
        lo = 0;
        hi = 0;
        if (v <= (on_y ? y_nodes[0] : x_nodes[0])) return;
        if (v >= (on_y ? y_nodes[n-1] : x_nodes[n-1])) begin
            lo = n - 1;
            hi = n - 1;
            return;
        end
        for (int i = 1; i < n; i++) begin
            a = on_y ? y_nodes[i] : x_nodes[i];
            if (v < a) begin
                lo = i - 1;
                hi = i;
                return;
            end
            if (v == a) begin
                lo = i;
                hi = i;
                return;
            end
        end
    endfunction

    function automatic out_item_t predict_query(logic signed [31:0] qx, logic signed [31:0] qy);
        int                  lx, ux, ly, uy;
        longint              x, y, f11, f21, f12, f22, x1, x2, y1, y2, res;
        logic signed [131:0] s;
        logic [63:0]         area;
        out_item_t           r;
        x = qx;
        y = qy;
        find_bracket(1'b0, nodes_in_use(x_count_reg), x, lx, ux);
        find_bracket(1'b1, nodes_in_use(y_count_reg), y, ly, uy);
        f11 = surface[lx][ly];
        f21 = surface[ux][ly];
        f12 = surface[lx][uy];
        f22 = surface[ux][uy];
        x1 = x_nodes[lx];
        x2 = x_nodes[ux];
        y1 = y_nodes[ly];
        y2 = y_nodes[uy];
        if (lx == ux && ly == uy) begin
            res = f11;
        end else if (lx == ux) begin
            res = sat32(f11 + quotient_trunc(wide(f12 - f11) * wide(y - y1), y2 - y1));
        end else if (ly == uy) begin
            res = sat32(f11 + quotient_trunc(wide(f21 - f11) * wide(x - x1), x2 - x1));
        end else begin
            s = wide(f11) * wide(x2 - x) * wide(y2 - y)
              + wide(f21) * wide(x - x1) * wide(y2 - y)
              + wide(f12) * wide(x2 - x) * wide(y - y1)
              + wide(f22) * wide(x - x1) * wide(y - y1);
            area = (x2 - x1) * (y2 - y1);
            // An area at or above 2^63 is divided in two steps: by half the area, then by two.
            if (area[63]) res = sat32(quotient_trunc(s, area >> 1) / 2);
            else res = sat32(quotient_trunc(s, area));
        end
        r.interp_value = res[31:0];
        r.x_lower_node = lx[6:0];
        r.y_lower_node = ly[6:0];
        r.on_node      = (lx == ux && ly == uy);
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            x_count_reg = 8'd128;
            y_count_reg = 8'd128;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_X_COUNT: x_count_reg = pwdata[7:0];
                    REG_Y_COUNT: y_count_reg = pwdata[7:0];
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_payload);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("interp_value", want.interp_value, m_payload.interp_value);
                    check_field("x_lower_node", want.x_lower_node, m_payload.x_lower_node);
                    check_field("y_lower_node", want.y_lower_node, m_payload.y_lower_node);
                    check_field("on_node", want.on_node, m_payload.on_node);
                end
            end
            if (s_valid && s_ready) begin
                case (s_payload.mode)
                    MODE_LOAD_X:    x_nodes[s_payload.row_index] = s_payload.load_value;
                    MODE_LOAD_Y:    y_nodes[s_payload.col_index] = s_payload.load_value;
                    MODE_LOAD_SURF: surface[s_payload.row_index][s_payload.col_index] =
                                        s_payload.load_value;
                    MODE_QUERY:     expected_q.push_back(
                                        predict_query(s_payload.query_x, s_payload.query_y));
                endcase
            end
        end
        pending_results = expected_q.size();
    end

endmodule

// File: tb/grid_bilinear_interpolator_tb.sv
`timescale 1ns / 100ps
// Top of the grid bilinear interpolator bench: clock, reset, APB setup and request traffic.
// Depends on gbi_pkg, grid_bilinear_interpolator and gbi_checker.
module grid_bilinear_interpolator_tb;
    import gbi_pkg::*;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam int DRAIN_CYCLES = 400;   // longer than the slowest query

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_payload;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_payload;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_results;

    // Stimulus-side copy of the axes, used to aim query points at nodes and cells.
    logic signed [31:0] x_axis [128];
    logic signed [31:0] y_axis [128];
    int nx, ny;
    int idle_pct, stall_pct;

    grid_bilinear_interpolator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gbi_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Stall the result channel at the phase's rate; change only on the falling edge.
    always @(negedge aclk) m_ready = ($urandom_range(99) >= stall_pct);

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(in_item_t r);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Build a request with random filler in the fields its mode does not use.
    task automatic send_load(logic [1:0] mode, int row, int col, logic signed [31:0] v);
        in_item_t r;
        r            = 112'({$urandom, $urandom, $urandom, $urandom});
        r.mode       = mode;
        r.row_index  = row[6:0];
        r.col_index  = col[6:0];
        r.load_value = v;
        send_request(r);
    endtask

    task automatic send_query(logic signed [31:0] qx, logic signed [31:0] qy);
        in_item_t r;
        r         = 112'({$urandom, $urandom, $urandom, $urandom});
        r.mode    = MODE_QUERY;
        r.query_x = qx;
        r.query_y = qy;
        send_request(r);
    endtask

    task automatic write_reg(logic reg_idx, logic [31:0] v);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {reg_idx, 2'b00};
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Hold until every expected result is back, then let any trailing load settle.
    task automatic drain();
        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic signed [31:0] surface_value();
        int k;
        k = $urandom_range(7);
        if (k == 0) return Q_MIN;
        if (k == 1) return Q_MAX;
        return $urandom;
    endfunction

    // Reprogram the counts, then load both axes and the whole grid in use.
    task automatic load_grid(logic [7:0] xc, logic [7:0] yc, int step_max, bit ordered);
        int step_cap;
        drain();
        write_reg(REG_X_COUNT, {8'($urandom_range(255)), 16'h0, xc} & 32'hFF00_00FF);
        write_reg(REG_Y_COUNT, {24'h0, yc});
        nx = (xc == 0) ? 1 : (xc > 128) ? 128 : xc;
        ny = (yc == 0) ? 1 : (yc > 128) ? 128 : yc;
        for (int i = 0; i < nx; i++) begin
            step_cap = (1 << 30) / nx;
            if (!ordered) x_axis[i] = $urandom;
            else if (i == 0) x_axis[i] = $signed($urandom) >>> 2;
            else x_axis[i] = x_axis[i-1] + $urandom_range(1, step_max < step_cap ?
                                                           step_max : step_cap);
            send_load(MODE_LOAD_X, i, $urandom_range(127), x_axis[i]);
        end
        for (int i = 0; i < ny; i++) begin
            step_cap = (1 << 30) / ny;
            if (!ordered) y_axis[i] = $urandom;
            else if (i == 0) y_axis[i] = $signed($urandom) >>> 2;
            else y_axis[i] = y_axis[i-1] + $urandom_range(1, step_max < step_cap ?
                                                           step_max : step_cap);
            send_load(MODE_LOAD_Y, $urandom_range(127), i, y_axis[i]);
        end
        for (int r = 0; r < nx; r++)
            for (int c = 0; c < ny; c++)
                send_load(MODE_LOAD_SURF, r, c, surface_value());
    endtask

    // Aim a coordinate at a node, next to one, in or just around the span, or anywhere at all.
    function automatic logic signed [31:0] pick_coord(bit on_y);
        int     k, n, idx;
        longint lo, hi, span, v;
        n   = on_y ? ny : nx;
        idx = $urandom_range(n - 1);
        k   = $urandom_range(99);
        v   = on_y ? y_axis[idx] : x_axis[idx];
        if (k < 25) return v[31:0];
        if (k < 35) return 32'(v + ($urandom_range(1) ? 1 : -1));
        if (k < 50) return $urandom;
        lo   = on_y ? y_axis[0] : x_axis[0];
        hi   = on_y ? y_axis[n-1] : x_axis[n-1];
        span = hi - lo;
        if (span <= 0) return $urandom;
        v = lo - span / 8 + (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF)
            % (span + span / 4 + 1);
        if (v > Q_MAX) v = Q_MAX;
        if (v < Q_MIN) v = Q_MIN;
        return v[31:0];
    endfunction

    // Mostly queries; surface reloads and harmless axis rewrites mixed in.
    task automatic run_queries(int count);
        int sent, p, idx;
        sent = 0;
        while (sent < count) begin
            p = $urandom_range(99);
            if (p < 82) begin
                send_query(pick_coord(1'b0), pick_coord(1'b1));
                sent++;
            end else if (p < 95) begin
                send_load(MODE_LOAD_SURF, $urandom_range(nx - 1), $urandom_range(ny - 1),
                          surface_value());
            end else begin
                // Rewrite a node in use with its own value, or one out of use freely.
                idx = $urandom_range(127);
                if (p < 97) begin
                    if (idx >= nx) x_axis[idx] = $urandom;
                    send_load(MODE_LOAD_X, idx, $urandom_range(127), x_axis[idx]);
                end else begin
                    if (idx >= ny) y_axis[idx] = $urandom;
                    send_load(MODE_LOAD_Y, $urandom_range(127), idx, y_axis[idx]);
                end
            end
        end
    endtask

    initial begin
        logic [7:0] xc_list [12];
        logic [7:0] yc_list [12];
        int         steps   [4];
        xc_list   = '{128, 6, 1, 0, 5, 12, 20, 3, 8, 1, 2, 7};
        yc_list   = '{1, 0, 9, 255, 7, 3, 2, 20, 8, 1, 2, 6};
        steps     = '{1 << 30, 4, 1000, 1 << 16};
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        m_ready   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a 2x2 grid spanning the whole Q16.16 range, so the cell area
        // exceeds 2^63, corner values sit at the extremes and results saturate.
        write_reg(REG_X_COUNT, 32'd2);
        write_reg(REG_Y_COUNT, 32'd2);
        nx = 2;
        ny = 2;
        x_axis[0] = Q_MIN; x_axis[1] = Q_MAX;
        y_axis[0] = Q_MIN; y_axis[1] = Q_MAX;
        send_load(MODE_LOAD_X, 0, 0, Q_MIN);
        send_load(MODE_LOAD_X, 1, 127, Q_MAX);
        send_load(MODE_LOAD_Y, 127, 0, Q_MIN);
        send_load(MODE_LOAD_Y, 0, 1, Q_MAX);
        send_load(MODE_LOAD_SURF, 0, 0, Q_MAX);
        send_load(MODE_LOAD_SURF, 1, 0, Q_MIN);
        send_load(MODE_LOAD_SURF, 0, 1, Q_MIN);
        send_load(MODE_LOAD_SURF, 1, 1, Q_MAX);
        send_load(MODE_LOAD_SURF, 127, 127, Q_MAX);
        send_query(Q_MIN, Q_MIN);                 // grid corner
        send_query(Q_MAX, Q_MAX);                 // far corner
        send_query(32'sd0, Q_MIN);                // on a y node, linear in x
        send_query(Q_MIN, 32'sd0);                // on an x node, linear in y
        send_query(32'sd0, 32'sd0);               // full cell, huge area
        send_query(32'sd1, -32'sd1);
        send_query(Q_MAX - 1, Q_MIN + 1);

        // Random phases: every count extreme, zero and over-depth counts, two
        // phases with unordered axes; idling rotates through four patterns.
        for (int ph = 0; ph < 12; ph++) begin
            load_grid(xc_list[ph], yc_list[ph], steps[ph % 4], ph != 7 && ph != 10);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            run_queries(30);
            idle_pct  = 0;
            stall_pct = 0;
        end

        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/gbi_pkg.sv
hw/rtl/gbi_axis_search.sv
hw/rtl/gbi_divider.sv
hw/rtl/grid_bilinear_interpolator.sv
tb/gbi_checker.sv
tb/grid_bilinear_interpolator_tb.sv
